FILE: hw/rtl/pts_pkg.sv
// Shared types, constants and helpers of the periodic timer scheduler.
// Depends on nothing; every other file of the block imports it.
package pts_pkg;

  // Number of timer slots. Kept in 2..256.
  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int ID_W   = 32;
  localparam int TIME_W = 48;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Depth of the request and result queues.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_REG   = 2'd1;
  localparam logic [1:0] FUNC_UNREG = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_FIRE  = 2'd1;
  localparam logic [1:0] KIND_UNREG = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ID_W-1:0]   period;
    logic [ID_W-1:0]   target;
    logic              target_nz;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] deadline;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] id;
    logic [1:0]      status;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic [ID_W-1:0]   period;
    logic [TIME_W-1:0] deadline;
  } slot_t;

  typedef struct packed {
    logic             scanning;
    logic [CNT_W-1:0] live_cnt;
  } back_stat_t;

  // Saturating time + offset.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [ID_W-1:0]   b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W - ID_W + 1){1'b0}}, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/pts_front.sv
// Request front end: decodes an incoming request and precomputes its deadline.
// Depends on pts_pkg; feeds pts_cmd_queue.
module pts_front
  import pts_pkg::*;
(
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_func,
  input  logic [ID_W-1:0]   in_period_ms,
  input  logic [ID_W-1:0]   in_delay_ms,
  input  logic [ID_W-1:0]   in_target_id,
  input  logic [TIME_W-1:0] in_now_ms,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              cmd
);

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    cmd.op        = in_func;
    cmd.period    = in_period_ms;
    cmd.target    = in_target_id;
    cmd.target_nz = (in_target_id != '0);
    cmd.now       = in_now_ms;
    cmd.deadline  = sat_add(in_now_ms, in_delay_ms);
  end

endmodule

FILE: hw/rtl/pts_cmd_queue.sv
// Short queue of decoded requests between the front end and the back end.
// Depends on pts_pkg.
module pts_cmd_queue
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output logic q_empty,
  output cmd_t rd_data
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/pts_res_queue.sv
// Output queue of result records, read through the empty/pop side.
// Depends on pts_pkg.
module pts_res_queue
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_data,
  output logic q_full,
  input  logic rd_en,
  output logic q_empty,
  output res_t rd_data
);

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

FILE: hw/rtl/pts_back.sv
// Back end: holds the timer slot table and carries out decoded requests.
// Depends on pts_pkg; reads pts_cmd_queue and writes pts_res_queue.
module pts_back
  import pts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic       res_full,
  output logic       res_push,
  output res_t       res,
  output back_stat_t stat
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  slot_t             slot_r   [SLOTS];
  slot_t             slot_nxt [SLOTS];

  logic [SLOTS-1:0]  match;
  logic              found;
  logic [CNT_W-1:0]  match_idx;
  logic              free_en;
  logic [CNT_W-1:0]  free_idx;
  slot_t             cur;
  logic              due;
  logic [ID_W-1:0]   id_inc;

  // Unregister lookup: oldest live slot whose identifier matches.
  always_comb begin
    found     = 1'b0;
    match_idx = '0;
    for (int k = 0; k < SLOTS; k++) begin
      match[k] = (CNT_W'(k) < cnt_r) && cmd.target_nz && (slot_r[k].ident == cmd.target);
    end
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (match[k]) begin
        found     = 1'b1;
        match_idx = CNT_W'(k);
      end
    end
  end

  assign cur    = slot_r[idx_r[SLOT_W-1:0]];
  assign due    = (cur.deadline <= now_r);
  assign id_inc = next_id_r + 1'b1;

  assign stat.scanning = (state_r == S_SCAN);
  assign stat.live_cnt = cnt_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    now_nxt     = now_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    next_id_nxt = next_id_r;
    slot_nxt    = slot_r;
    free_en     = 1'b0;
    free_idx    = '0;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            FUNC_REG: begin
              res_push  = 1'b1;
              res.kind  = KIND_REG;
              res.last  = 1'b1;
              if (cnt_r == CNT_W'(SLOTS)) begin
                res.status = STAT_FULL;
              end else begin
                res.id   = next_id_r;
                slot_nxt[cnt_r[SLOT_W-1:0]].ident    = next_id_r;
                slot_nxt[cnt_r[SLOT_W-1:0]].period   = cmd.period;
                slot_nxt[cnt_r[SLOT_W-1:0]].deadline = cmd.deadline;
                cnt_nxt     = cnt_r + 1'b1;
                // skip zero on wrap
                next_id_nxt = (id_inc == '0) ? ID_W'(1) : id_inc;
              end
            end
            FUNC_UNREG: begin
              res_push   = 1'b1;
              res.kind   = KIND_UNREG;
              res.id     = cmd.target;
              res.last   = 1'b1;
              res.status = found ? STAT_OK : STAT_NOT_FOUND;
              if (found) begin
                free_en  = 1'b1;
                free_idx = match_idx;
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            FUNC_CLEAR: begin
              res_push = 1'b1;
              res.kind = KIND_CLEAR;
              res.last = 1'b1;
              cnt_nxt  = '0;
            end
            FUNC_TICK: begin
              state_nxt  = S_SCAN;
              idx_nxt    = '0;
              now_nxt    = cmd.now;
              pend_v_nxt = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx_r < cnt_r) begin
          if (!due) begin
            idx_nxt = idx_r + 1'b1;
          end else if (!(pend_v_r && res_full)) begin
            // release the previous firing, hold this one until we know if it is last
            if (pend_v_r) begin
              res_push = 1'b1;
              res.kind = KIND_FIRE;
              res.id   = pend_id_r;
            end
            pend_v_nxt  = 1'b1;
            pend_id_nxt = cur.ident;
            if (cur.period == '0) begin
              free_en  = 1'b1;
              free_idx = idx_r;
              cnt_nxt  = cnt_r - 1'b1;
            end else begin
              slot_nxt[idx_r[SLOT_W-1:0]].deadline = sat_add(now_r, cur.period);
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (!res_full) begin
          res_push   = 1'b1;
          res.kind   = KIND_FIRE;
          res.id     = pend_id_r;
          res.last   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
    endcase

    // Compact: slide later entries down over a freed slot.
    if (free_en) begin
      for (int k = 0; k < SLOTS - 1; k++) begin
        if (CNT_W'(k) >= free_idx) begin
          slot_nxt[k] = slot_r[k + 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      idx_r     <= '0;
      pend_v_r  <= 1'b0;
      next_id_r <= ID_W'(1);
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      pend_v_r  <= pend_v_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    pend_id_r <= pend_id_nxt;
    slot_r    <= slot_nxt;
  end

endmodule

FILE: hw/rtl/periodic_timer_scheduler.sv
// Periodic and one-shot timer table, top level.
// Register, unregister and clear are each done as the back end takes them; a tick is taken,
// then visits each live slot in turn and closes the scan. A full result queue adds stalls.
// A lone result shows on the result side in the cycle after its request is taken; requests
// run one at a time, and non-tick requests follow at one a cycle while results are popped.
// Synchronous active-low reset empties the table and sets the next identifier to one.
module periodic_timer_scheduler
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // request side
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_func,
  input  logic [ID_W-1:0]   in_period_ms,
  input  logic [ID_W-1:0]   in_delay_ms,
  input  logic [ID_W-1:0]   in_target_id,
  input  logic [TIME_W-1:0] in_now_ms,
  // result side
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        out_result_kind,
  output logic [ID_W-1:0]   out_timer_id,
  output logic [1:0]        out_status,
  output logic              out_last
);

  logic       fq_push, fq_full, fq_empty, cmd_pop;
  cmd_t       fq_wdata, fq_rdata;
  logic       rq_push, rq_full;
  res_t       rq_wdata, rq_rdata;
  back_stat_t stat;

  // Decode the request and work out its first deadline.
  pts_front u_front (
    .push         (push),
    .full         (full),
    .in_func      (in_func),
    .in_period_ms (in_period_ms),
    .in_delay_ms  (in_delay_ms),
    .in_target_id (in_target_id),
    .in_now_ms    (in_now_ms),
    .q_full       (fq_full),
    .q_push       (fq_push),
    .cmd          (fq_wdata)
  );

  // Decouple the front end from a back end that may be busy scanning.
  pts_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_wdata),
    .q_full  (fq_full),
    .rd_en   (cmd_pop),
    .q_empty (fq_empty),
    .rd_data (fq_rdata)
  );

  // Slot table and request execution.
  pts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!fq_empty),
    .cmd       (fq_rdata),
    .cmd_pop   (cmd_pop),
    .res_full  (rq_full),
    .res_push  (rq_push),
    .res       (rq_wdata),
    .stat      (stat)
  );

  // Buffer results so the back end keeps going while the consumer stalls.
  pts_res_queue u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rq_push),
    .wr_data (rq_wdata),
    .q_full  (rq_full),
    .rd_en   (pop),
    .q_empty (empty),
    .rd_data (rq_rdata)
  );

  assign out_result_kind = rq_rdata.kind;
  assign out_timer_id    = rq_rdata.id;
  assign out_status      = rq_rdata.status;
  assign out_last        = rq_rdata.last;

  // Live count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.live_cnt <= CNT_W'(SLOTS))
    else $error("live count above table size");

  // No new request is taken from the queue while a tick scan runs.
  a_no_pop_scan: assert property (@(posedge clk) disable iff (!rst_n)
    stat.scanning |-> !cmd_pop)
    else $error("request popped during scan");

  // A firing always carries status ok.
  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == KIND_FIRE) |-> out_status == STAT_OK)
    else $error("fired result with bad status");

  // A full-table answer carries identifier zero.
  a_full_id: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_result_kind == KIND_REG && out_status == STAT_FULL) |->
      out_timer_id == '0)
    else $error("full answer with nonzero identifier");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking bench for periodic_timer_scheduler: random queue traffic on both sides,
// expected timer answers and firings predicted by a scoreboard class.
// Depends on pts_pkg and periodic_timer_scheduler from hw/rtl.

import pts_pkg::*;

localparam int FIRE_LIMIT = 16;

class timer_scoreboard;
  logic [ID_W-1:0]   ident    [SLOTS];
  logic [ID_W-1:0]   period   [SLOTS];
  logic [TIME_W-1:0] deadline [SLOTS];
  int                live_cnt;
  logic [ID_W-1:0]   next_id;
  res_t              expected_q [$];
  int                errors;
  int                results_seen;
  int                fired;
  int                full_hits;
  int                misses;

  function new();
    live_cnt     = 0;
    next_id      = 1;
    errors       = 0;
    results_seen = 0;
    fired        = 0;
    full_hits    = 0;
    misses       = 0;
  endfunction

  function void report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endfunction

  // Time plus offset, clamped at the top of the time range.
  function logic [TIME_W-1:0] arm_time(logic [TIME_W-1:0] base, logic [ID_W-1:0] ofs);
    logic [TIME_W:0] sum;
    sum = {1'b0, base} + {{(TIME_W - ID_W + 1){1'b0}}, ofs};
    if (sum[TIME_W]) return {TIME_W{1'b1}};
    return sum[TIME_W-1:0];
  endfunction

  // Remove one entry; later entries move down to keep registration order.
  function void drop_slot(int k);
    for (int i = k; i < live_cnt - 1; i++) begin
      ident[i]    = ident[i+1];
      period[i]   = period[i+1];
      deadline[i] = deadline[i+1];
    end
    live_cnt--;
  endfunction

  function void queue_answer(logic [1:0] kind, logic [ID_W-1:0] id, logic [1:0] st);
    res_t r;
    r.kind   = kind;
    r.id     = id;
    r.status = st;
    r.last   = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endfunction

  function logic [ID_W-1:0] pick_live_id();
    if (live_cnt == 0) return '0;
    return ident[$urandom_range(0, live_cnt - 1)];
  endfunction

  function void note_request(logic [1:0] func, logic [ID_W-1:0] per, logic [ID_W-1:0] dly,
                             logic [ID_W-1:0] tgt, logic [TIME_W-1:0] now);
    int         first;
    int         i;
    int         nfire;
    bit         found;
    logic [1:0] st;
    res_t       tail;
    first = expected_q.size();
    case (func)
      FUNC_REG: begin
        if (live_cnt >= SLOTS) begin
          queue_answer(KIND_REG, '0, STAT_FULL);
          full_hits++;
        end else begin
          ident[live_cnt]    = next_id;
          period[live_cnt]   = per;
          deadline[live_cnt] = arm_time(now, dly);
          live_cnt++;
          queue_answer(KIND_REG, next_id, STAT_OK);
          next_id = next_id + 1;
          if (next_id == 0) next_id = 1;
        end
      end
      FUNC_UNREG: begin
        found = 1'b0;
        st    = STAT_NOT_FOUND;
        if (tgt != 0) begin
          for (i = 0; i < live_cnt && !found; i++) begin
            if (ident[i] == tgt) begin
              drop_slot(i);
              found = 1'b1;
              st    = STAT_OK;
            end
          end
        end
        if (!found) misses++;
        queue_answer(KIND_UNREG, tgt, st);
      end
      FUNC_CLEAR: begin
        live_cnt = 0;
        queue_answer(KIND_CLEAR, '0, STAT_OK);
      end
      default: begin
        i     = 0;
        nfire = 0;
        while (i < live_cnt && nfire < FIRE_LIMIT) begin
          if (deadline[i] <= now) begin
            queue_answer(KIND_FIRE, ident[i], STAT_OK);
            nfire++;
            fired++;
            if (period[i] == 0) begin
              drop_slot(i);
            end else begin
              deadline[i] = arm_time(now, period[i]);
              i++;
            end
          end else begin
            i++;
          end
        end
      end
    endcase
    if (expected_q.size() > first) begin
      tail      = expected_q[expected_q.size() - 1];
      tail.last = 1'b1;
      expected_q[expected_q.size() - 1] = tail;
    end
  endfunction

  function void check_result(logic [1:0] kind, logic [ID_W-1:0] id, logic [1:0] st,
                             logic last);
    res_t exp_r;
    results_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("result kind=%0d id=%0d status=%0d with none expected", kind, id, st));
      return;
    end
    exp_r = expected_q.pop_front();
    if (kind !== exp_r.kind)
      report($sformatf("result_kind got %0d want %0d", kind, exp_r.kind));
    if (id !== exp_r.id)
      report($sformatf("timer_id got %0d want %0d", id, exp_r.id));
    if (st !== exp_r.status)
      report($sformatf("status got %0d want %0d", st, exp_r.status));
    if (last !== exp_r.last)
      report($sformatf("last got %0d want %0d", last, exp_r.last));
  endfunction
endclass

module tb_top;
  logic              clk = 1'b0;
  logic              rst_n;
  logic              push;
  logic              full;
  logic [1:0]        in_func;
  logic [ID_W-1:0]   in_period_ms;
  logic [ID_W-1:0]   in_delay_ms;
  logic [ID_W-1:0]   in_target_id;
  logic [TIME_W-1:0] in_now_ms;
  logic              empty;
  logic              pop;
  logic [1:0]        out_result_kind;
  logic [ID_W-1:0]   out_timer_id;
  logic [1:0]        out_status;
  logic              out_last;

  timer_scoreboard   sb;
  logic [TIME_W-1:0] cur_now;
  bit                calm_in  = 1'b0;
  bit                calm_out = 1'b0;
  int                op_count [4];

  periodic_timer_scheduler u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_period_ms    (in_period_ms),
    .in_delay_ms     (in_delay_ms),
    .in_target_id    (in_target_id),
    .in_now_ms       (in_now_ms),
    .empty           (empty),
    .pop             (pop),
    .out_result_kind (out_result_kind),
    .out_timer_id    (out_timer_id),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  always #2 clk = ~clk;

  // Idle length before the next handshake: mostly none or short, now and then long.
  // A calm stretch gives back-to-back traffic.
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until the block takes it. Keep push high across
  // back-to-back requests so it is never dropped and raised in the same step.
  task automatic send(input logic [1:0] func, input logic [ID_W-1:0] per,
                      input logic [ID_W-1:0] dly, input logic [ID_W-1:0] tgt,
                      input logic [TIME_W-1:0] now);
    int gap;
    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
    gap = pick_gap(calm_in);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push         <= 1'b1;
    in_func      <= func;
    in_period_ms <= per;
    in_delay_ms  <= dly;
    in_target_id <= tgt;
    in_now_ms    <= now;
    // full is sampled before this edge's updates land, so this is the handshake value.
    do @(posedge clk); while (full);
    sb.note_request(func, per, dly, tgt, now);
    op_count[func]++;
  endtask

  // Random period: one-shot often, short repeat mostly, any 32-bit value sometimes.
  function automatic logic [ID_W-1:0] rand_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return '0;
    if (r < 85) return ID_W'($urandom_range(1, 40));
    return ID_W'($urandom);
  endfunction

  function automatic logic [ID_W-1:0] rand_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return ID_W'($urandom_range(0, 40));
    if (r < 95) return ID_W'($urandom_range(41, 500));
    return ID_W'($urandom);
  endfunction

  // Unregister targets: mostly a live timer, else zero, a recent identifier or noise.
  function automatic logic [ID_W-1:0] rand_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return sb.pick_live_id();
    if (r < 80) return '0;
    if (r < 90) return sb.next_id - ID_W'($urandom_range(1, 4));
    return ID_W'($urandom);
  endfunction

  // Result side: pop with random stalls and check each accepted result in order.
  initial begin : result_side
    int gap;
    pop = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
      gap = pick_gap(calm_out);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(out_result_kind, out_timer_id, out_status, out_last);
    end
  end

  // Safety net well past the slowest legal run.
  initial begin : watchdog
    #10000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int               k;
    int               r;
    logic [ID_W-1:0]  per;
    logic [TIME_W-1:0] max_time;
    sb           = new();
    max_time     = {TIME_W{1'b1}};
    rst_n        = 1'b0;
    push         = 1'b0;
    in_func      = FUNC_TICK;
    in_period_ms = '0;
    in_delay_ms  = '0;
    in_target_id = '0;
    in_now_ms    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    // Idle tick on an empty table at time zero: no result.
    send(FUNC_TICK, ID_W'($urandom), ID_W'($urandom), ID_W'($urandom), '0);
    // Target zero never matches.
    send(FUNC_UNREG, '0, '0, '0, 48'd1000);
    // Fill every slot with a mix of one-shot, short and longest periods.
    for (k = 0; k < SLOTS; k++) begin
      per = (k % 3 == 0) ? '0 : ((k % 3 == 1) ? ID_W'(5) : {ID_W{1'b1}});
      send(FUNC_REG, per, ID_W'(k), ID_W'($urandom), 48'd1000);
    end
    // Table full: no store, no identifier used up.
    send(FUNC_REG, 32'd7, 32'd7, '0, 48'd1000);
    // Every entry due at once; one-shots drop out, the rest re-arm.
    send(FUNC_TICK, '0, '0, '0, 48'd1020);
    send(FUNC_UNREG, '0, '0, 32'd5, 48'd1021);
    send(FUNC_UNREG, '0, '0, 32'd5, 48'd1021);
    send(FUNC_CLEAR, {ID_W{1'b1}}, {ID_W{1'b1}}, {ID_W{1'b1}}, 48'd1022);
    // Deadline and re-arm saturate at the top of the time range.
    send(FUNC_REG, {ID_W{1'b1}}, {ID_W{1'b1}}, '0, max_time - 48'd3);
    send(FUNC_TICK, '0, '0, '0, max_time);
    send(FUNC_TICK, '0, '0, '0, max_time);
    send(FUNC_CLEAR, '0, '0, '0, max_time);

    // Random part. Identifier wrap needs 2^32 registrations and is out of reach here.
    cur_now = 48'd2000;
    for (k = 0; k < 480; k++) begin
      r = $urandom_range(0, 99);
      cur_now = cur_now + TIME_W'($urandom_range(0, 3));
      if (r < 34) begin
        send(FUNC_REG, rand_period(), rand_delay(), ID_W'($urandom), cur_now);
      end else if (r < 70) begin
        cur_now = cur_now + TIME_W'($urandom_range(0, 25));
        send(FUNC_TICK, ID_W'($urandom), ID_W'($urandom), ID_W'($urandom), cur_now);
      end else if (r < 92) begin
        send(FUNC_UNREG, ID_W'($urandom), ID_W'($urandom), rand_target(), cur_now);
      end else if (r < 96) begin
        send(FUNC_CLEAR, ID_W'($urandom), ID_W'($urandom), ID_W'($urandom), cur_now);
      end else begin
        // Jump time anywhere in the range, then tick.
        cur_now = {16'($urandom), 32'($urandom)};
        send(FUNC_TICK, ID_W'($urandom), ID_W'($urandom), ID_W'($urandom), cur_now);
      end
    end
    push <= 1'b0;

    // Drain, then give a full tick scan's worth of cycles for anything stray.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

    $display("Ran %0d requests: %0d tick, %0d register, %0d unregister, %0d clear; %0d results.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[FUNC_TICK],
             op_count[FUNC_REG], op_count[FUNC_UNREG], op_count[FUNC_CLEAR],
             sb.results_seen);
    $display("Saw %0d firings, %0d full-table answers, %0d unknown-identifier answers.",
             sb.fired, sb.full_hits, sb.misses);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/pts_pkg.sv
hw/rtl/pts_front.sv
hw/rtl/pts_cmd_queue.sv
hw/rtl/pts_res_queue.sv
hw/rtl/pts_back.sv
hw/rtl/periodic_timer_scheduler.sv
tb/sv/tb_top.sv
